// ===== hdl/pfr_pkg.sv =====
// package: shared constants, types and table functions of the power falloff ramp
package pfr_pkg;

   localparam int MaxWidth = 4096;
   localparam int CsrAddrW = 4;
   localparam int CsrDataW = 32;
   localparam int RootW = 28;
   localparam int RemW = 56;
   localparam int NumW = 28;
   localparam int DW = 17;
   localparam int LogSteps = 16;
   localparam int MantW = 31;
   localparam int ExpW = 31;
   localparam int TabW = 30;

   localparam logic [12:0] RampWidthReset = 13'd256;
   localparam logic [15:0] FalloffExpReset = 16'd4096;
   localparam logic RadialModeReset = 1'b0;

   typedef enum logic [1:0] {
      REG_RAMP_WIDTH  = 2'd0,
      REG_FALLOFF_EXP = 2'd1,
      REG_RADIAL_MODE = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic force_full;
      logic force_zero;
      logic d_one;
      logic d_zero;
   } side_type;

   typedef struct packed {
      side_type side;
      logic [RemW-1:0] rem;
      logic [RootW-1:0] root;
   } rt_type;

   typedef struct packed {
      side_type side;
      logic [NumW-1:0] rem;
      logic [DW-1:0] q;
   } dv_type;

   typedef struct packed {
      side_type side;
      logic [DW-1:0] d;
   } d_type;

   typedef struct packed {
      side_type side;
      logic [3:0] k;
      logic [15:0] f;
      logic [MantW-1:0] m;
   } lg_type;

   typedef struct packed {
      side_type side;
      logic [8:0] n;
      logic [15:0] g;
      logic [ExpW-1:0] e;
   } ex_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bit_w;
      rem = v;
      res = 64'd0;
      for (int i = 31; i >= 0; i--) begin
         bit_w = 64'd1 << (2 * i);
         if (rem >= res + bit_w) begin
            rem = rem - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
      end
      return res;
   endfunction

   // 2^(-2^-idx) in q.30
   function automatic logic [TabW-1:0] exp_tab(input int idx);
      logic [63:0] t;
      t = 64'd1 << 29;
      for (int i = 1; i <= idx; i++) begin
         t = isqrt64(t << 30);
      end
      return t[TabW-1:0];
   endfunction

endpackage

// ===== hdl/power_falloff_ramp_pixel.sv =====
// top level: power falloff ramp pixel generator with register port
//
// a request carries one pixel coordinate (req_pixel_x, req_pixel_y) on a
// valid/ready channel; each request yields exactly one rsp_intensity on the
// rsp_ channel, in request order
// the pipeline is 82 register stages: 2 front stages (saturation, squared
// radius), 28 square root stages, 17 divider stages, 18 log2 stages (entry,
// 16 squaring steps, exponent product), 16 exp2 stages and the output register
// one request per cycle is taken and one result per cycle is given when the
// receiver keeps up
// each stage holds its own valid bit, so bubbles close up while the receiver
// stalls and requests keep being taken until every stage is full
// reset clears all valid bits and loads the registers with width 256,
// exponent 1.0 and linear mode
// registers: ramp_width at 0x0, falloff_exponent at 0x4, radial_mode at 0x8;
// write them only while no request is in flight
module power_falloff_ramp_pixel
   import pfr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [11:0]         req_pixel_x,
   input  logic [11:0]         req_pixel_y,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_intensity,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready
);

   logic [12:0] ramp_width_ff;
   logic [15:0] falloff_exp_ff;
   logic        radial_mode_ff;
   logic [23:0] wm1sq_ff;
   logic [12:0] wcl;
   logic [11:0] wm1;
   reg_idx_type csr_idx;

   logic   f_valid, f_ready;
   rt_type f_data;
   logic   r_valid, r_ready;
   dv_type r_data;
   logic   d_valid, d_ready;
   d_type  d_data;
   logic   l_valid, l_ready;
   ex_type l_data;

   assign csr_idx = reg_idx_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_width_ff <= RampWidthReset;
         falloff_exp_ff <= FalloffExpReset;
         radial_mode_ff <= RadialModeReset;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_idx)
            REG_RAMP_WIDTH:  ramp_width_ff <= csr_pwdata[12:0];
            REG_FALLOFF_EXP: falloff_exp_ff <= csr_pwdata[15:0];
            REG_RADIAL_MODE: radial_mode_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_RAMP_WIDTH:  csr_prdata = CsrDataW'(ramp_width_ff);
         REG_FALLOFF_EXP: csr_prdata = CsrDataW'(falloff_exp_ff);
         REG_RADIAL_MODE: csr_prdata = CsrDataW'(radial_mode_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (ramp_width_ff < 13'd2) begin
         wcl = 13'd2;
      end else if (ramp_width_ff > 13'(MaxWidth)) begin
         wcl = 13'(MaxWidth);
      end else begin
         wcl = ramp_width_ff;
      end
      wm1 = 12'(wcl - 13'd1);
   end

   always_ff @(posedge clock) begin
      wm1sq_ff <= wm1 * wm1;
   end

   pfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .radial    (radial_mode_ff),
      .wm1       (wm1),
      .wm1sq     (wm1sq_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_x      (req_pixel_x),
      .in_y      (req_pixel_y),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_data  (f_data)
   );

   pfr_root u_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (r_valid),
      .out_ready (r_ready),
      .out_data  (r_data)
   );

   pfr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .wm1       (wm1),
      .in_valid  (r_valid),
      .in_ready  (r_ready),
      .in_data   (r_data),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_data  (d_data)
   );

   pfr_log u_log (
      .clock     (clock),
      .reset     (reset),
      .fall_exp  (falloff_exp_ff),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .in_data   (d_data),
      .out_valid (l_valid),
      .out_ready (l_ready),
      .out_data  (l_data)
   );

   pfr_exp u_exp (
      .clock         (clock),
      .reset         (reset),
      .fall_exp      (falloff_exp_ff),
      .in_valid      (l_valid),
      .in_ready      (l_ready),
      .in_data       (l_data),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_intensity (rsp_intensity)
   );

endmodule

// ===== hdl/pfr_front.sv =====
// front stages: coordinate saturation, centre offsets, squared radius and end flags
module pfr_front
   import pfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        radial,
   input  logic [11:0] wm1,
   input  logic [23:0] wm1sq,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [11:0] in_x,
   input  logic [11:0] in_y,
   output logic        out_valid,
   input  logic        out_ready,
   output rt_type      out_data
);

   logic        v1_ff;
   logic [11:0] xs_ff;
   logic [11:0] a_ff;
   logic [11:0] b_ff;
   side_type    side1_ff;
   logic [11:0] xs_in;
   logic [11:0] ys_in;
   logic [12:0] w13;
   logic [12:0] tx;
   logic [12:0] ty;
   logic [12:0] a_in;
   logic [12:0] b_in;
   side_type    side1_in;

   logic        v2_ff;
   rt_type      st2_ff;
   rt_type      st2_in;
   logic [24:0] s;

   logic rdy1;
   logic rdy2;

   assign rdy2 = !v2_ff || out_ready;
   assign rdy1 = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      xs_in = (in_x > wm1) ? wm1 : in_x;
      ys_in = (in_y > wm1) ? wm1 : in_y;
      w13 = {1'b0, wm1} + 13'd1;
      tx = {xs_in, 1'b1};
      ty = {ys_in, 1'b1};
      a_in = (tx >= w13) ? (tx - w13) : (w13 - tx);
      b_in = (ty >= w13) ? (ty - w13) : (w13 - ty);
      side1_in = '0;
      if (radial) begin
         side1_in.force_zero = (xs_in == 12'd0) || (ys_in == 12'd0) ||
                               (xs_in == wm1) || (ys_in == wm1);
      end else begin
         side1_in.force_full = (xs_in == 12'd0);
         side1_in.force_zero = (xs_in != 12'd0) && (xs_in == wm1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= in_valid;
      end
      if (rdy1) begin
         xs_ff <= xs_in;
         a_ff <= a_in[11:0];
         b_ff <= b_in[11:0];
         side1_ff <= side1_in;
      end
   end

   always_comb begin
      s = 25'(a_ff) * 25'(a_ff) + 25'(b_ff) * 25'(b_ff);
      st2_in.side = side1_ff;
      st2_in.side.d_one = radial && (s >= {1'b0, wm1sq});
      if (radial) begin
         st2_in.rem = {s[23:0], 32'd0};
         st2_in.root = '0;
      end else begin
         st2_in.rem = '0;
         st2_in.root = {xs_ff, 16'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
      if (rdy2) begin
         st2_ff <= st2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data = st2_ff;

endmodule

// ===== hdl/pfr_root.sv =====
// square root pipeline, one result bit per stage
module pfr_root
   import pfr_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   in_valid,
   output logic   in_ready,
   input  rt_type in_data,
   output logic   out_valid,
   input  logic   out_ready,
   output dv_type out_data
);

   rt_type           stg_ff [RootW];
   logic [RootW-1:0] vld_ff;
   rt_type           src_data [RootW];
   logic [RootW-1:0] src_v;
   logic [RootW:0]   rdy;

   assign rdy[RootW] = out_ready;

   for (genvar j = 0; j < RootW; j++) begin : g_stage
      localparam int B = RootW - 1 - j;
      logic [57:0] delta;
      rt_type      stg_in;

      if (j == 0) begin : g_first
         assign src_data[j] = in_data;
         assign src_v[j] = in_valid;
      end else begin : g_next
         assign src_data[j] = stg_ff[j-1];
         assign src_v[j] = vld_ff[j-1];
      end

      assign rdy[j] = !vld_ff[j] || rdy[j+1];
      assign delta = ({30'd0, src_data[j].root} << (B + 1)) | (58'd1 << (2 * B));

      always_comb begin
         stg_in = src_data[j];
         if ({2'b00, src_data[j].rem} >= delta) begin
            stg_in.rem = src_data[j].rem - delta[RemW-1:0];
            stg_in.root = src_data[j].root | (RootW'(1) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (rdy[j]) begin
            vld_ff[j] <= src_v[j];
         end
         if (rdy[j]) begin
            stg_ff[j] <= stg_in;
         end
      end
   end

   assign in_ready = rdy[0];
   assign out_valid = vld_ff[RootW-1];
   assign out_data.side = stg_ff[RootW-1].side;
   assign out_data.rem = stg_ff[RootW-1].root;
   assign out_data.q = '0;

endmodule

// ===== hdl/pfr_div.sv =====
// restoring divider pipeline by width minus one, one quotient bit per stage
module pfr_div
   import pfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [11:0] wm1,
   input  logic        in_valid,
   output logic        in_ready,
   input  dv_type      in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output d_type       out_data
);

   dv_type        stg_ff [DW];
   logic [DW-1:0] vld_ff;
   dv_type        src_data [DW];
   logic [DW-1:0] src_v;
   logic [DW:0]   rdy;

   assign rdy[DW] = out_ready;

   for (genvar j = 0; j < DW; j++) begin : g_stage
      localparam int J = DW - 1 - j;
      logic [NumW-1:0] sub;
      dv_type          stg_in;

      if (j == 0) begin : g_first
         assign src_data[j] = in_data;
         assign src_v[j] = in_valid;
      end else begin : g_next
         assign src_data[j] = stg_ff[j-1];
         assign src_v[j] = vld_ff[j-1];
      end

      assign rdy[j] = !vld_ff[j] || rdy[j+1];
      assign sub = NumW'(wm1) << J;

      always_comb begin
         stg_in = src_data[j];
         if (src_data[j].rem >= sub) begin
            stg_in.rem = src_data[j].rem - sub;
            stg_in.q = src_data[j].q | (DW'(1) << J);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (rdy[j]) begin
            vld_ff[j] <= src_v[j];
         end
         if (rdy[j]) begin
            stg_ff[j] <= stg_in;
         end
      end
   end

   always_comb begin
      out_data.side = stg_ff[DW-1].side;
      out_data.side.d_one = stg_ff[DW-1].side.d_one || stg_ff[DW-1].q[DW-1];
      out_data.d = stg_ff[DW-1].q;
   end

   assign in_ready = rdy[0];
   assign out_valid = vld_ff[DW-1];

endmodule

// ===== hdl/pfr_log.sv =====
// log2 pipeline by repeated squaring, then exponent product
module pfr_log
   import pfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] fall_exp,
   input  logic        in_valid,
   output logic        in_ready,
   input  d_type       in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output ex_type      out_data
);

   localparam int Last = LogSteps + 1;

   logic [Last+1:0] rdy;
   logic [Last:0]   vld_ff;
   lg_type          stg_ff [LogSteps+1];
   lg_type          ent_in;
   ex_type          prd_ff;
   ex_type          prd_in;
   logic [20:0]     nl;
   logic [36:0]     prod;

   assign rdy[Last+1] = out_ready;
   for (genvar j = 0; j <= Last; j++) begin : g_rdy
      assign rdy[j] = !vld_ff[j] || rdy[j+1];
   end

   always_comb begin
      ent_in.side = in_data.side;
      ent_in.side.d_zero = (in_data.d == '0);
      ent_in.k = '0;
      for (int i = 0; i < 16; i++) begin
         if (in_data.d[i]) begin
            ent_in.k = 4'(i);
         end
      end
      ent_in.f = '0;
      ent_in.m = MantW'(in_data.d[15:0]) << (5'd30 - {1'b0, ent_in.k});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         vld_ff[0] <= in_valid;
      end
      if (rdy[0]) begin
         stg_ff[0] <= ent_in;
      end
   end

   for (genvar i = 1; i <= LogSteps; i++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] t;
      lg_type      stg_in;

      assign sq = 62'(stg_ff[i-1].m) * 62'(stg_ff[i-1].m);
      assign t = sq[61:30];

      always_comb begin
         stg_in = stg_ff[i-1];
         if (t[31]) begin
            stg_in.m = t[31:1];
            stg_in.f = stg_ff[i-1].f | (16'd1 << (16 - i));
         end else begin
            stg_in.m = t[30:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         if (rdy[i]) begin
            stg_ff[i] <= stg_in;
         end
      end
   end

   always_comb begin
      nl = {5'd16 - {1'b0, stg_ff[LogSteps].k}, 16'd0} - {5'd0, stg_ff[LogSteps].f};
      prod = 37'(fall_exp) * 37'(nl);
      prd_in.side = stg_ff[LogSteps].side;
      prd_in.n = prod[36:28];
      prd_in.g = prod[27:12];
      prd_in.e = ExpW'(1) << 30;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[Last] <= 1'b0;
      end else if (rdy[Last]) begin
         vld_ff[Last] <= vld_ff[Last-1];
      end
      if (rdy[Last]) begin
         prd_ff <= prd_in;
      end
   end

   assign in_ready = rdy[0];
   assign out_valid = vld_ff[Last];
   assign out_data = prd_ff;

endmodule

// ===== hdl/pfr_exp.sv =====
// exp2 pipeline over the fraction bits, final scaling and output register
module pfr_exp
   import pfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] fall_exp,
   input  logic        in_valid,
   output logic        in_ready,
   input  ex_type      in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [7:0]  out_intensity
);

   ex_type              stg_ff [LogSteps];
   logic [LogSteps-1:0] vld_ff;
   ex_type              src_data [LogSteps];
   logic [LogSteps-1:0] src_v;
   logic [LogSteps:0]   rdy;

   logic        res_v_ff;
   logic [7:0]  res_ff;
   logic [7:0]  res_in;
   logic [16:0] qsh;
   logic [16:0] q;
   logic [16:0] diff;
   logic [24:0] scaled;
   ex_type      fin;

   assign rdy[LogSteps] = !res_v_ff || out_ready;

   for (genvar j = 0; j < LogSteps; j++) begin : g_stage
      localparam logic [TabW-1:0] TabVal = exp_tab(j + 1);
      logic [60:0] prod;
      ex_type      stg_in;

      if (j == 0) begin : g_first
         assign src_data[j] = in_data;
         assign src_v[j] = in_valid;
      end else begin : g_next
         assign src_data[j] = stg_ff[j-1];
         assign src_v[j] = vld_ff[j-1];
      end

      assign rdy[j] = !vld_ff[j] || rdy[j+1];
      assign prod = 61'(src_data[j].e) * 61'(TabVal);

      always_comb begin
         stg_in = src_data[j];
         if (src_data[j].g[15-j]) begin
            stg_in.e = prod[60:30];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (rdy[j]) begin
            vld_ff[j] <= src_v[j];
         end
         if (rdy[j]) begin
            stg_ff[j] <= stg_in;
         end
      end
   end

   always_comb begin
      fin = stg_ff[LogSteps-1];
      if (fin.n > 9'd16) begin
         qsh = '0;
      end else begin
         qsh = fin.e[30:14] >> fin.n[4:0];
      end
      if (fall_exp == 16'd0 || fin.side.d_one) begin
         q = 17'h10000;
      end else if (fin.side.d_zero) begin
         q = '0;
      end else begin
         q = qsh;
      end
      diff = 17'h10000 - q;
      scaled = {diff, 8'd0} - 25'(diff);
      if (fin.side.force_full) begin
         res_in = 8'd255;
      end else if (fin.side.force_zero) begin
         res_in = 8'd0;
      end else begin
         res_in = scaled[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_v_ff <= 1'b0;
      end else if (rdy[LogSteps]) begin
         res_v_ff <= vld_ff[LogSteps-1];
      end
      if (rdy[LogSteps]) begin
         res_ff <= res_in;
      end
   end

   assign in_ready = rdy[0];
   assign out_valid = res_v_ff;
   assign out_intensity = res_ff;

endmodule

// ===== hdl/pfr_checker.sv =====
// port checker for the power falloff ramp and its bind
module pfr_checker
   import pfr_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [7:0]          rsp_intensity,
   input logic [CsrAddrW-1:0] csr_paddr,
   input logic [CsrDataW-1:0] csr_prdata,
   input logic                csr_pready
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_intensity))
      else $error("stalled result changed or dropped");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("register port not ready");

   a_width_read: assert property (@(posedge clock)
      csr_paddr[3:2] == REG_RAMP_WIDTH |-> csr_prdata[31:13] == '0)
      else $error("width register reads wide bits");

   a_mode_read: assert property (@(posedge clock)
      csr_paddr[3:2] == REG_RADIAL_MODE |-> csr_prdata[31:1] == '0)
      else $error("mode register reads wide bits");

endmodule

bind power_falloff_ramp_pixel pfr_checker u_pfr_checker (.*);
